// ----- rtl/igr_pkg.sv -----
// ----------------------------------------------------------------------------
// igr_pkg: shared constants for the interleaved gain ramp
// Field widths, register indexes, reset values and parameter defaults.
// ----------------------------------------------------------------------------
package igr_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int GAIN_W    = 16;
    localparam int SPC_W     = 13;
    localparam int CHC_W     = 4;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    localparam int ACC_FRAC_BITS = 30;

    localparam int DEF_MAX_SAMPLES    = 4096;
    localparam int DEF_MAX_CHANNELS   = 8;
    localparam int DEF_GAIN_FRAC_BITS = 14;

    localparam logic [CFG_IDX_W-1:0] REG_START_GAIN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_GAIN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SPC         = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CHAN_COUNT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_MUTED = 3'd4;

    localparam logic [GAIN_W-1:0] RST_START_GAIN  = 16'd16384;
    localparam logic [GAIN_W-1:0] RST_TARGET_GAIN = 16'd16384;
    localparam logic [SPC_W-1:0]  RST_SPC         = 13'd480;
    localparam logic [CHC_W-1:0]  RST_CHAN_COUNT  = 4'd1;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7fff;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

endpackage

// ----- rtl/igr_if.sv -----
// ----------------------------------------------------------------------------
// igr_if: channel interfaces of the interleaved gain ramp
// Sample input, sample output and register write channels.
// ----------------------------------------------------------------------------
interface igr_in_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [igr_pkg::SAMPLE_W-1:0]  sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

interface igr_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [igr_pkg::SAMPLE_W-1:0]  sample_out;
    logic                                 last_of_frame;

    modport source (output valid, output sample_out, output last_of_frame, input ready);
    modport sink   (input valid, input sample_out, input last_of_frame, output ready);
endinterface

interface igr_cfg_if;
    logic                                 valid;
    logic                                 ready;
    logic [igr_pkg::CFG_IDX_W-1:0]        index;
    logic [igr_pkg::CFG_DAT_W-1:0]        data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/interleaved_gain_ramp_top.sv -----
// ----------------------------------------------------------------------------
// interleaved_gain_ramp_top: linear gain ramp over interleaved frames
// Scales each sample by a gain that ramps from start to target gain; a sample
// passes unchanged when muted or when start and target gain are equal.
//   channel   dir  beat payload                     notes
//   i_sample  in   sample_in                        ready only while idle
//   o_sample  out  sample_out, last_of_frame        held in output register
//   i_cfg     in   index, data                      always ready
//
// A sample goes through accept, multiply and saturate into the output register.
// The first sample of a frame also runs the step division in the divider first.
// Reset (synchronous, active low) loads register defaults and zeroes frame state.
// A stalled output holds the next result in the saturate step until it drains.
// ----------------------------------------------------------------------------
module interleaved_gain_ramp_top #(
    parameter int MAX_SAMPLES    = igr_pkg::DEF_MAX_SAMPLES,
    parameter int MAX_CHANNELS   = igr_pkg::DEF_MAX_CHANNELS,
    parameter int GAIN_FRAC_BITS = igr_pkg::DEF_GAIN_FRAC_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    igr_in_if.sink      i_sample,
    igr_out_if.source   o_sample,
    igr_cfg_if.sink     i_cfg
);

    localparam int SPC_W    = igr_pkg::SPC_W;
    localparam int CHC_W    = igr_pkg::CHC_W;
    localparam int SHIFT    = igr_pkg::ACC_FRAC_BITS - GAIN_FRAC_BITS;
    localparam int DIVD_W   = igr_pkg::GAIN_W + SHIFT;
    localparam int STEP_W   = DIVD_W + 1;
    localparam int ACC_W    = STEP_W + SPC_W + 1;
    localparam int G_W      = ACC_W - SHIFT;
    localparam int SPC_MAXV = (1 << SPC_W) - 1;
    localparam int CHC_MAXV = (1 << CHC_W) - 1;
    localparam int SPC_LIM  = (MAX_SAMPLES > SPC_MAXV) ? SPC_MAXV : MAX_SAMPLES;
    localparam int CH_LIM   = (MAX_CHANNELS > CHC_MAXV) ? CHC_MAXV : MAX_CHANNELS;
    localparam int PIDX_RAW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int PIDX_W   = (PIDX_RAW > SPC_W) ? SPC_W : PIDX_RAW;
    localparam int CIDX_RAW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int CIDX_W   = (CIDX_RAW > CHC_W) ? CHC_W : CIDX_RAW;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_MUL  = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    logic [igr_pkg::GAIN_W-1:0] r_start, r_target;
    logic [SPC_W-1:0]           r_spc;
    logic [CHC_W-1:0]           r_chc;
    logic                       r_muted;

    logic [1:0]                 r_state;
    logic [PIDX_W-1:0]          r_pidx;
    logic [CIDX_W-1:0]          r_cidx;
    logic signed [ACC_W-1:0]    r_acc;
    logic signed [STEP_W-1:0]   r_step;
    logic                       r_neg;
    logic                       r_bypass;
    logic                       r_last_ch;
    logic                       r_last_frm;
    logic signed [igr_pkg::SAMPLE_W-1:0] r_s;
    logic                       r_out_valid;
    logic signed [igr_pkg::SAMPLE_W-1:0] r_out_data;
    logic                       r_out_last;

    logic [SPC_W-1:0]           spc_c;
    logic [CHC_W-1:0]           ch_c;
    logic                       in_acc;
    logic                       out_acc;
    logic                       frame_start;
    logic                       last_ch;
    logic                       last_per;
    logic [igr_pkg::GAIN_W-1:0] mag;
    logic [DIVD_W-1:0]          quot;
    logic                       div_busy;
    logic signed [igr_pkg::SAMPLE_W-1:0] scaled;
    logic                       out_load;

    always_comb begin
        if (r_spc == '0) begin
            spc_c = SPC_W'(1);
        end else if (r_spc > SPC_W'(SPC_LIM)) begin
            spc_c = SPC_W'(SPC_LIM);
        end else begin
            spc_c = r_spc;
        end
        if (r_chc == '0) begin
            ch_c = CHC_W'(1);
        end else if (r_chc > CHC_W'(CH_LIM)) begin
            ch_c = CHC_W'(CH_LIM);
        end else begin
            ch_c = r_chc;
        end
    end

    assign in_acc      = i_sample.valid && i_sample.ready;
    assign out_acc     = o_sample.valid && o_sample.ready;
    assign frame_start = (r_pidx == '0) && (r_cidx == '0);
    assign last_ch     = ((CHC_W+1)'(r_cidx) + 1'b1) >= {1'b0, ch_c};
    assign last_per    = ((SPC_W+1)'(r_pidx) + 1'b1) >= {1'b0, spc_c};
    assign mag         = (r_target < r_start) ? (r_start - r_target) : (r_target - r_start);
    assign out_load    = (r_state == ST_OUT) && (!r_out_valid || o_sample.ready);

    assign i_sample.ready = r_state == ST_IDLE;
    assign i_cfg.ready    = 1'b1;

    igr_divider #(
        .DVD_W (DIVD_W),
        .DVS_W (SPC_W)
    ) u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (in_acc && frame_start),
        .i_dividend ({mag, {SHIFT{1'b0}}}),
        .i_divisor  (spc_c),
        .o_busy     (div_busy),
        .o_quotient (quot)
    );

    igr_scale #(
        .G_W       (G_W),
        .FRAC_BITS (GAIN_FRAC_BITS)
    ) u_scale (
        .i_clk    (i_clk),
        .i_load   (r_state == ST_MUL),
        .i_sample (r_s),
        .i_gain   (r_acc[ACC_W-1:SHIFT]),
        .i_bypass (r_bypass),
        .o_result (scaled)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start  <= igr_pkg::RST_START_GAIN;
            r_target <= igr_pkg::RST_TARGET_GAIN;
            r_spc    <= igr_pkg::RST_SPC;
            r_chc    <= igr_pkg::RST_CHAN_COUNT;
            r_muted  <= 1'b0;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                igr_pkg::REG_START_GAIN:  r_start  <= i_cfg.data;
                igr_pkg::REG_TARGET_GAIN: r_target <= i_cfg.data;
                igr_pkg::REG_SPC:         r_spc    <= i_cfg.data[SPC_W-1:0];
                igr_pkg::REG_CHAN_COUNT:  r_chc    <= i_cfg.data[CHC_W-1:0];
                igr_pkg::REG_FRAME_MUTED: r_muted  <= i_cfg.data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pidx      <= '0;
            r_cidx      <= '0;
            r_acc       <= '0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        r_cidx <= last_ch ? '0 : CIDX_W'(r_cidx + 1'b1);
                        if (last_ch) begin
                            r_pidx <= last_per ? '0 : PIDX_W'(r_pidx + 1'b1);
                        end
                        if (frame_start) begin
                            r_acc   <= {{(ACC_W-DIVD_W){1'b0}}, r_start, {SHIFT{1'b0}}};
                            r_state <= ST_DIV;
                        end else begin
                            r_state <= ST_MUL;
                        end
                    end
                end
                ST_DIV: begin
                    if (!div_busy) begin
                        r_step  <= r_neg ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
                        r_state <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    r_state <= ST_OUT;
                end
                ST_OUT: begin
                    if (out_load) begin
                        if (r_last_ch) begin
                            r_acc <= r_acc + ACC_W'(r_step);
                        end
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (out_acc) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s        <= i_sample.sample_in;
            r_neg      <= r_target < r_start;
            r_bypass   <= (r_start == r_target) || r_muted;
            r_last_ch  <= last_ch;
            r_last_frm <= last_ch && last_per;
        end
        if (out_load) begin
            r_out_data <= scaled;
            r_out_last <= r_last_frm;
        end
    end

    assign o_sample.valid         = r_out_valid;
    assign o_sample.sample_out    = r_out_data;
    assign o_sample.last_of_frame = r_out_last;

    a_div_on_frame_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && frame_start) |=> div_busy)
        else $error("divider not started on first beat of frame");

    a_div_only_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_busy |-> (r_state == ST_DIV))
        else $error("divider busy outside division state");

    a_chan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (CHC_W'(r_cidx) < CHC_W'(CH_LIM)))
        else $error("channel position beyond channel limit");

endmodule

// ----- rtl/igr_divider.sv -----
// ----------------------------------------------------------------------------
// igr_divider: restoring unsigned divider, one quotient bit per cycle
// Subtract-and-compare unit that produces the per-period ramp step.
// ----------------------------------------------------------------------------
module igr_divider #(
    parameter int DVD_W = 30,
    parameter int DVS_W = 13
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic             o_busy,
    output logic [DVD_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [DVS_W-1:0] r_rem, n_rem;
    logic [DVS_W-1:0] r_dvs, n_dvs;
    logic [DVD_W-1:0] r_quot, n_quot;
    logic [DVS_W:0]   rem_sh;
    logic [DVS_W:0]   rem_sub;
    logic             fits;

    always_comb begin
        rem_sh  = {r_rem, r_quot[DVD_W-1]};
        rem_sub = rem_sh - {1'b0, r_dvs};
        fits    = rem_sh >= {1'b0, r_dvs};
        n_cnt   = r_cnt;
        n_rem   = r_rem;
        n_dvs   = r_dvs;
        n_quot  = r_quot;
        if (i_start) begin
            n_cnt  = CNT_W'(DVD_W);
            n_rem  = '0;
            n_dvs  = i_divisor;
            n_quot = i_dividend;
        end else if (r_cnt != '0) begin
            n_cnt  = r_cnt - 1'b1;
            n_rem  = fits ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
            n_quot = {r_quot[DVD_W-2:0], fits};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
        r_rem  <= n_rem;
        r_dvs  <= n_dvs;
        r_quot <= n_quot;
    end

    assign o_busy     = r_cnt != '0;
    assign o_quotient = r_quot;

endmodule

// ----- rtl/igr_scale.sv -----
// ----------------------------------------------------------------------------
// igr_scale: sample times gain, truncate toward zero, saturate
// Registered product, then shift and clamp to the sample range.
// ----------------------------------------------------------------------------
module igr_scale #(
    parameter int G_W       = 31,
    parameter int FRAC_BITS = 14
) (
    input  logic                                i_clk,
    input  logic                                i_load,
    input  logic signed [igr_pkg::SAMPLE_W-1:0] i_sample,
    input  logic signed [G_W-1:0]               i_gain,
    input  logic                                i_bypass,
    output logic signed [igr_pkg::SAMPLE_W-1:0] o_result
);

    localparam int PROD_W = igr_pkg::SAMPLE_W + G_W;
    localparam int EXT_W  = PROD_W - igr_pkg::SAMPLE_W;

    logic signed [PROD_W-1:0]           r_prod;
    logic signed [igr_pkg::SAMPLE_W-1:0] r_sample;
    logic                               r_bypass;
    logic signed [PROD_W-1:0]           adj;
    logic signed [PROD_W-1:0]           shifted;
    logic signed [PROD_W-1:0]           sat_hi;
    logic signed [PROD_W-1:0]           sat_lo;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_prod   <= PROD_W'(i_sample) * PROD_W'(i_gain);
            r_sample <= i_sample;
            r_bypass <= i_bypass;
        end
    end

    always_comb begin
        sat_hi  = {{EXT_W{1'b0}}, igr_pkg::SAMPLE_MAX};
        sat_lo  = {{EXT_W{1'b1}}, igr_pkg::SAMPLE_MIN};
        adj     = r_prod + {{(PROD_W-FRAC_BITS){1'b0}}, {FRAC_BITS{r_prod[PROD_W-1]}}};
        shifted = adj >>> FRAC_BITS;
        if (r_bypass) begin
            o_result = r_sample;
        end else if (shifted > sat_hi) begin
            o_result = igr_pkg::SAMPLE_MAX;
        end else if (shifted < sat_lo) begin
            o_result = igr_pkg::SAMPLE_MIN;
        end else begin
            o_result = shifted[igr_pkg::SAMPLE_W-1:0];
        end
    end

endmodule

// ----- bench/igr_ramp_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// igr_ramp_checker: scoreboard for the interleaved gain ramp
// Follows register writes and sample beats, predicts every scaled beat with
// its own gain ramp and frame position, and compares each output beat in
// order. Hands the mismatch count and the number of open beats to the top.
// ----------------------------------------------------------------------------
module igr_ramp_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    igr_in_if    i_sample,
    igr_out_if   i_result,
    igr_cfg_if   i_cfg,
    output int   o_fail_count,
    output int   o_pending
);
    import igr_pkg::*;

    localparam int GAIN_SHIFT = ACC_FRAC_BITS - DEF_GAIN_FRAC_BITS;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last;
    } scaled_beat_t;

    logic [GAIN_W-1:0] start_gain_q;
    logic [GAIN_W-1:0] target_gain_q;
    logic [SPC_W-1:0]  frame_len_q;
    logic [CHC_W-1:0]  chan_cnt_q;
    logic              mute_q;

    longint      gain_acc;
    longint      gain_inc;
    int unsigned period_pos;
    int unsigned chan_pos;

    scaled_beat_t scaled_q[$];
    int           fails = 0;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("[%0t] mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
        fails++;
    endtask

    function automatic scaled_beat_t ramp_sample(input logic signed [SAMPLE_W-1:0] s);
        int unsigned  periods;
        int unsigned  chans;
        longint       diff;
        longint       prod;
        longint       mag;
        longint       y;
        logic         last_chan;
        logic         last_period;
        scaled_beat_t beat;

        periods = (frame_len_q == '0) ? 1 :
                  (frame_len_q > DEF_MAX_SAMPLES) ? DEF_MAX_SAMPLES : frame_len_q;
        chans   = (chan_cnt_q == '0) ? 1 :
                  (chan_cnt_q > DEF_MAX_CHANNELS) ? DEF_MAX_CHANNELS : chan_cnt_q;

        if (period_pos == 0 && chan_pos == 0) begin
            diff     = longint'(target_gain_q) - longint'(start_gain_q);
            gain_acc = longint'(start_gain_q) <<< GAIN_SHIFT;
            gain_inc = (diff <<< GAIN_SHIFT) / longint'(periods);
        end

        if (start_gain_q == target_gain_q || mute_q) begin
            y = longint'(s);
        end else begin
            prod = longint'(s) * (gain_acc >>> GAIN_SHIFT);
            mag  = (prod < 0) ? -prod : prod;
            mag  = mag >> DEF_GAIN_FRAC_BITS;
            y    = (prod < 0) ? -mag : mag;
            if (y > longint'(SAMPLE_MAX)) y = longint'(SAMPLE_MAX);
            if (y < longint'(SAMPLE_MIN)) y = longint'(SAMPLE_MIN);
        end

        last_chan   = (chan_pos + 1 >= chans);
        last_period = (period_pos + 1 >= periods);
        beat.sample = y[SAMPLE_W-1:0];
        beat.last   = last_chan && last_period;

        if (last_chan) begin
            chan_pos   = 0;
            gain_acc  += gain_inc;
            period_pos = last_period ? 0 : period_pos + 1;
        end else begin
            chan_pos = chan_pos + 1;
        end
        return beat;
    endfunction

    always @(posedge i_clk) begin
        scaled_beat_t want;
        if (!i_rst_n) begin
            start_gain_q  = RST_START_GAIN;
            target_gain_q = RST_TARGET_GAIN;
            frame_len_q   = RST_SPC;
            chan_cnt_q    = RST_CHAN_COUNT;
            mute_q        = 1'b0;
            gain_acc      = 0;
            gain_inc      = 0;
            period_pos    = 0;
            chan_pos      = 0;
            scaled_q.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    REG_START_GAIN:  start_gain_q  = i_cfg.data[GAIN_W-1:0];
                    REG_TARGET_GAIN: target_gain_q = i_cfg.data[GAIN_W-1:0];
                    REG_SPC:         frame_len_q   = i_cfg.data[SPC_W-1:0];
                    REG_CHAN_COUNT:  chan_cnt_q    = i_cfg.data[CHC_W-1:0];
                    REG_FRAME_MUTED: mute_q        = i_cfg.data[0];
                    default: ;
                endcase
            end
            if (i_sample.valid && i_sample.ready) begin
                scaled_q.push_back(ramp_sample(i_sample.sample_in));
            end
            if (i_result.valid && i_result.ready) begin
                if (scaled_q.size() == 0) begin
                    report_mismatch("beat with nothing expected, sample_out",
                                    longint'(i_result.sample_out), 0);
                end else begin
                    want = scaled_q.pop_front();
                    if (i_result.sample_out !== want.sample) begin
                        report_mismatch("sample_out", longint'(i_result.sample_out),
                                        longint'(want.sample));
                    end
                    if (i_result.last_of_frame !== want.last) begin
                        report_mismatch("last_of_frame", longint'(i_result.last_of_frame),
                                        longint'(want.last));
                    end
                end
            end
        end
        o_pending    <= scaled_q.size();
        o_fail_count <= fails;
    end

endmodule

// ----- bench/interleaved_gain_ramp_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interleaved_gain_ramp_top_tb: testbench top for the interleaved gain ramp
// Drives register writes and sample beats with random gaps and output stalls,
// runs a directed pass over extremes and corner settings followed by random
// phases of settings and frames, and gives the verdict from the checker.
// ----------------------------------------------------------------------------
module interleaved_gain_ramp_top_tb;
    import igr_pkg::*;

    localparam int TOTAL_ITEMS = 1720;
    localparam int HOLD_CYCLES = 200;
    localparam int STALL_LIMIT = 2000;
    localparam int TAIL_CYCLES = 60;

    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HI = 3'd7;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    igr_in_if  in_ch ();
    igr_out_if out_ch ();
    igr_cfg_if cfg_ch ();

    int fail_count;
    int pending;
    int samples_sent = 0;
    bit in_calm      = 1'b0;
    bit out_calm     = 1'b0;
    bit hold_req     = 1'b0;

    always #2 i_clk = ~i_clk;

    interleaved_gain_ramp_top dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sample (in_ch),
        .o_sample (out_ch),
        .i_cfg    (cfg_ch)
    );

    igr_ramp_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_sample     (in_ch),
        .i_result     (out_ch),
        .i_cfg        (cfg_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] word);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= word;
        do @(posedge i_clk); while (!(cfg_ch.valid && cfg_ch.ready));
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic write_all(input logic [CFG_DAT_W-1:0] sg, input logic [CFG_DAT_W-1:0] tg,
                             input logic [CFG_DAT_W-1:0] spc, input logic [CFG_DAT_W-1:0] chs,
                             input logic [CFG_DAT_W-1:0] mute);
        cfg_write(REG_START_GAIN, sg);
        cfg_write(REG_TARGET_GAIN, tg);
        cfg_write(REG_SPC, spc);
        cfg_write(REG_CHAN_COUNT, chs);
        cfg_write(REG_FRAME_MUTED, mute);
    endtask

    task automatic push_sample(input logic signed [SAMPLE_W-1:0] s);
        int gap;
        gap = in_calm ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.sample_in <= s;
        do @(posedge i_clk); while (!(in_ch.valid && in_ch.ready));
        samples_sent++;
    endtask

    task automatic drain_results();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 7))
            0: return SAMPLE_MAX;
            1: return SAMPLE_MIN;
            2: return SAMPLE_W'($urandom_range(0, 16)) - SAMPLE_W'(8);
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    task automatic random_setup();
        logic [GAIN_W-1:0]    sg;
        logic [GAIN_W-1:0]    tg;
        logic [CFG_DAT_W-1:0] word;
        case ($urandom_range(0, 5))
            0: begin
                sg = GAIN_W'($urandom);
                tg = sg;
            end
            1: begin
                sg = '0;
                tg = '1;
            end
            2: begin
                sg = '1;
                tg = '0;
            end
            default: begin
                sg = GAIN_W'($urandom);
                tg = GAIN_W'($urandom);
            end
        endcase
        if ($urandom_range(0, 3) != 0) cfg_write(REG_START_GAIN, sg);
        if ($urandom_range(0, 3) != 0) cfg_write(REG_TARGET_GAIN, tg);
        if ($urandom_range(0, 3) != 0) begin
            word = CFG_DAT_W'($urandom);
            case ($urandom_range(0, 9))
                0: word[SPC_W-1:0] = '0;
                1: word[SPC_W-1:0] = SPC_W'(DEF_MAX_SAMPLES);
                2: ;
                default: word[SPC_W-1:0] = SPC_W'($urandom_range(1, 12));
            endcase
            cfg_write(REG_SPC, word);
        end
        if ($urandom_range(0, 3) != 0) begin
            word = CFG_DAT_W'($urandom);
            if ($urandom_range(0, 4) != 0) begin
                word[CHC_W-1:0] = CHC_W'($urandom_range(1, DEF_MAX_CHANNELS));
            end
            cfg_write(REG_CHAN_COUNT, word);
        end
        if ($urandom_range(0, 2) != 0) begin
            word    = CFG_DAT_W'($urandom);
            word[0] = ($urandom_range(0, 5) == 0);
            cfg_write(REG_FRAME_MUTED, word);
        end
        if ($urandom_range(0, 3) == 0) begin
            cfg_write($urandom_range(0, 1) ? REG_UNMAPPED_LO : REG_UNMAPPED_HI,
                      CFG_DAT_W'($urandom));
        end
    endtask

    initial begin : receiver
        int stall;
        out_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_req) begin
                stall    = HOLD_CYCLES;
                hold_req = 1'b0;
            end else begin
                stall = out_calm ? 0 : $urandom_range(0, 7);
            end
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!(out_ch.valid && out_ch.ready));
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
                    || (cfg_ch.valid && cfg_ch.ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("CHECK FAILED");
        $finish;
    end

    initial begin : stimulus
        int phase;
        int span;
        in_ch.valid     <= 1'b0;
        in_ch.sample_in <= '0;
        cfg_ch.valid    <= 1'b0;
        cfg_ch.index    <= '0;
        cfg_ch.data     <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // pass-through at reset settings
        push_sample(SAMPLE_MAX);
        push_sample(SAMPLE_MIN);
        push_sample('0);
        push_sample(-16'sd1);
        push_sample(16'sd1);

        // zero frame length and channel count, largest gain, saturation
        drain_results();
        write_all('1, '0, '0, '0, '0);
        push_sample(SAMPLE_MAX);
        push_sample(SAMPLE_MIN);
        push_sample(16'sd1);
        push_sample(-16'sd1);
        push_sample(16'sd12345);

        // oversized limits with junk upper bits, muted then unmuted mid-frame
        drain_results();
        write_all('0, '1, '1, '1, '1);
        push_sample(SAMPLE_MAX);
        push_sample(SAMPLE_MIN);
        push_sample(-16'sd300);
        drain_results();
        cfg_write(REG_FRAME_MUTED, '0);
        push_sample(SAMPLE_MAX);
        push_sample(SAMPLE_MIN);
        push_sample(16'sd777);

        // lower limits mid-frame, poke unmapped registers
        drain_results();
        cfg_write(REG_SPC, CFG_DAT_W'(2));
        cfg_write(REG_CHAN_COUNT, CFG_DAT_W'(2));
        cfg_write(REG_UNMAPPED_LO, '1);
        cfg_write(REG_UNMAPPED_HI, '1);
        repeat (6) push_sample(pick_sample());

        phase = 0;
        while (samples_sent < TOTAL_ITEMS) begin
            drain_results();
            random_setup();
            in_calm  = ($urandom_range(0, 3) == 0);
            out_calm = ($urandom_range(0, 3) == 0);
            if (phase == 2 || $urandom_range(0, 11) == 0) begin
                in_calm  = 1'b1;
                hold_req = 1'b1;
            end
            span = $urandom_range(8, 90);
            repeat (span) push_sample(pick_sample());
            phase++;
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ----- interleaved_gain_ramp_top.f -----
rtl/igr_pkg.sv
rtl/igr_if.sv
rtl/igr_divider.sv
rtl/igr_scale.sv
rtl/interleaved_gain_ramp_top.sv
bench/igr_ramp_checker.sv
bench/interleaved_gain_ramp_top_tb.sv
